### hdl/bfu_pkg.sv
// shared types, constants and helper functions for the flow table update block
`timescale 1ns / 1ps

package bfu_pkg;

    // table geometry
    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NB_W    = $clog2(BUCKETS + 1);

    // bucket count register
    localparam int          BC_W     = 11;
    localparam logic [10:0] BC_RESET = 11'd1024;

    // network protocols
    localparam logic [15:0] PROTO_V4 = 16'h0800;
    localparam logic [15:0] PROTO_V6 = 16'h86DD;

    // hash constants
    localparam logic [31:0] MIX_XOR = 32'd61;
    localparam logic [31:0] MIX_MUL = 32'h27d4eb2d;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PROTO = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0] net_proto;
        logic [7:0]  trans_proto;
        logic [63:0] src_words_01;
        logic [63:0] src_words_23;
        logic [63:0] dst_words_01;
        logic [63:0] dst_words_23;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic [15:0] pkt_length;
        logic [63:0] pkt_time;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] flow_number;
        logic        is_new;
        logic        direction;
        logic [63:0] up_pkts;
        logic [63:0] up_octets;
        logic [63:0] down_pkts;
        logic [63:0] down_octets;
        logic [63:0] total_pkts;
        logic [63:0] total_octets;
        logic [63:0] seen_time;
    } out_t;

    // one stored flow
    typedef struct packed {
        logic [15:0] net_proto;
        logic [7:0]  trans_proto;
        logic [63:0] a_words_01;
        logic [63:0] a_words_23;
        logic [63:0] b_words_01;
        logic [63:0] b_words_23;
        logic [15:0] a_port;
        logic [15:0] b_port;
        logic [31:0] number;
        logic [63:0] up_pkts;
        logic [63:0] up_octets;
        logic [63:0] down_pkts;
        logic [63:0] down_octets;
        logic [63:0] total_pkts;
        logic [63:0] total_octets;
        logic [63:0] seen_time;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // hash unit request and response
    typedef struct packed {
        logic        start;
        logic [31:0] key;
    } hreq_t;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } hrsp_t;

    // first part of the integer mix, before the multiply
    function automatic logic [31:0] mix_pre(input logic [31:0] k);
        logic [31:0] a;
        logic [31:0] b;
        a = (k ^ MIX_XOR) ^ (k >> 16);
        b = a + (a << 3);
        return b ^ (b >> 4);
    endfunction

    // address compare; ipv4 looks at word 0 only
    function automatic logic addr_eq(input logic v6, input logic [63:0] x01,
                                     input logic [63:0] x23, input logic [63:0] y01,
                                     input logic [63:0] y23);
        logic r;
        if (!v6) begin
            r = (x01[31:0] == y01[31:0]);
        end else begin
            r = (x01 == y01) && (x23 == y23);
        end
        return r;
    endfunction

endpackage

### hdl/bfu_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/bfu_hash.sv
// key mix with one multiply, then bit-serial modulo by the bucket count
`timescale 1ns / 1ps

module bfu_hash (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bfu_pkg::hreq_t           req,
    input  logic [bfu_pkg::NB_W-1:0] nb,
    output bfu_pkg::hrsp_t           rsp
);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_MUL  = 3'd1;
    localparam logic [2:0] H_FIN  = 3'd2;
    localparam logic [2:0] H_DIV  = 3'd3;
    localparam logic [2:0] H_DONE = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [31:0]              k_reg, k_next;
    logic [31:0]              quo_reg, quo_next;
    logic [bfu_pkg::NB_W-1:0] rem_reg, rem_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [bfu_pkg::NB_W:0]   trial;
    logic [31:0]              prod;

    assign prod  = k_reg * bfu_pkg::MIX_MUL;
    assign trial = {rem_reg, quo_reg[31]};

    // sequencer and subtract unit for the modulo
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            H_IDLE: begin
                if (req.start) begin
                    k_next     = bfu_pkg::mix_pre(req.key);
                    state_next = H_MUL;
                end
            end
            H_MUL: begin
                k_next     = prod;
                state_next = H_FIN;
            end
            H_FIN: begin
                quo_next   = k_reg ^ (k_reg >> 15);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = H_DIV;
            end
            H_DIV: begin
                // one quotient bit per cycle
                if (trial >= {1'b0, nb}) begin
                    rem_next = bfu_pkg::NB_W'(trial - {1'b0, nb});
                end else begin
                    rem_next = bfu_pkg::NB_W'(trial);
                end
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = H_DONE;
                end
            end
            H_DONE: begin
                state_next = H_IDLE;
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done   = (state_reg == H_DONE);
    assign rsp.bucket = bfu_pkg::BKT_W'(rem_reg);

endmodule

### hdl/bidirectional_flow_table_update.sv
// Bidirectional flow table: each header is hashed to a bucket, the bucket's ways
// are searched in order, each way read in S_RD and compared in S_CMP, until a
// match or the last way, and the matched or new flow is updated and returned; a
// bucket with no match and no free way returns ST_FULL. A header with a known
// protocol passes the accept state, the key mix, the bit-serial modulo unit, the
// way search, the update state and the output state; the modulo unit takes most
// of that time. An unknown protocol goes from the accept state to the output state.
// After reset a clearing pass wipes the valid bits one bucket a cycle; no header
// is accepted during it, while bucket_count writes are taken at any time.
`timescale 1ns / 1ps

module bidirectional_flow_table_update (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [bfu_pkg::BC_W-1:0]     cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bfu_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bfu_pkg::out_t                m_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [bfu_pkg::BC_W-1:0]      bucket_count_reg, bucket_count_next;
    logic [bfu_pkg::BKT_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [31:0]                   flow_num_reg, flow_num_next;
    logic                          hit_reg, hit_next;
    logic                          free_found_reg, free_found_next;
    logic [bfu_pkg::WAY_W-1:0]     free_way_reg, free_way_next;
    logic [bfu_pkg::WAY_W-1:0]     way_reg, way_next;
    bfu_pkg::in_t                  in_reg, in_next;
    logic                          v6_reg, v6_next;
    logic [bfu_pkg::BKT_W-1:0]     bucket_reg, bucket_next;
    bfu_pkg::out_t                 out_reg, out_next;

    bfu_pkg::hreq_t                hreq;
    bfu_pkg::hrsp_t                hrsp;
    logic [bfu_pkg::NB_W-1:0]      nb;
    logic [31:0]                   bc32;

    logic                          vr_we, vr_re;
    logic [bfu_pkg::BKT_W-1:0]     vr_waddr;
    logic [bfu_pkg::WAYS-1:0]      vr_wdata, vr_rdata;
    logic                          er_we, er_re;
    logic [bfu_pkg::ENTRY_W-1:0]   er_waddr, er_raddr;
    logic [bfu_pkg::ENTRY_BITS-1:0] er_rdata;
    bfu_pkg::entry_t               rd_ent, base_ent, new_ent;

    logic [31:0]                   key_v4, key_v6, key_fold;
    logic [15:0]                   pxor;
    logic                          is_v4, is_v6;
    logic                          cur_valid, cur_match;
    logic                          up;
    logic [63:0]                   len64;
    logic [bfu_pkg::WAY_W-1:0]     wsel;

    // effective divisor: zero reads as one, large values saturate
    assign bc32 = 32'(bucket_count_reg);
    always_comb begin
        if (bc32 == 32'd0) begin
            nb = bfu_pkg::NB_W'(1);
        end else if (bc32 > 32'(bfu_pkg::BUCKETS)) begin
            nb = bfu_pkg::NB_W'(bfu_pkg::BUCKETS);
        end else begin
            nb = bfu_pkg::NB_W'(bc32);
        end
    end

    // direction independent key
    assign is_v4  = (s_data.net_proto == bfu_pkg::PROTO_V4);
    assign is_v6  = (s_data.net_proto == bfu_pkg::PROTO_V6);
    assign key_v4 = s_data.src_words_01[31:0] ^ s_data.dst_words_01[31:0];
    assign key_v6 = key_v4 ^ s_data.src_words_01[63:32] ^ s_data.dst_words_01[63:32]
                  ^ s_data.src_words_23[31:0] ^ s_data.dst_words_23[31:0]
                  ^ s_data.src_words_23[63:32] ^ s_data.dst_words_23[63:32];
    assign pxor     = s_data.src_l4_port ^ s_data.dst_l4_port;
    assign key_fold = (is_v6 ? key_v6 : key_v4) ^ {pxor, pxor};

    bfu_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hreq),
        .nb      (nb),
        .rsp     (hrsp)
    );

    bfu_ram #(
        .WIDTH (bfu_pkg::WAYS),
        .DEPTH (bfu_pkg::BUCKETS)
    ) u_valid_ram (
        .clk   (aclk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata (vr_wdata),
        .re    (vr_re),
        .raddr (bucket_reg),
        .rdata (vr_rdata)
    );

    bfu_ram #(
        .WIDTH (bfu_pkg::ENTRY_BITS),
        .DEPTH (bfu_pkg::ENTRIES)
    ) u_entry_ram (
        .clk   (aclk),
        .we    (er_we),
        .waddr (er_waddr),
        .wdata (base_ent),
        .re    (er_re),
        .raddr (er_raddr),
        .rdata (er_rdata)
    );

    assign rd_ent = bfu_pkg::entry_t'(er_rdata);

    // compare of the way just read against the held header
    assign cur_valid = vr_rdata[way_reg];
    assign cur_match = (rd_ent.net_proto == in_reg.net_proto)
        && (rd_ent.trans_proto == in_reg.trans_proto)
        && (((rd_ent.a_port == in_reg.src_l4_port) && (rd_ent.b_port == in_reg.dst_l4_port))
         || ((rd_ent.a_port == in_reg.dst_l4_port) && (rd_ent.b_port == in_reg.src_l4_port)))
        && ((bfu_pkg::addr_eq(v6_reg, rd_ent.a_words_01, rd_ent.a_words_23,
                              in_reg.src_words_01, in_reg.src_words_23)
          && bfu_pkg::addr_eq(v6_reg, rd_ent.b_words_01, rd_ent.b_words_23,
                              in_reg.dst_words_01, in_reg.dst_words_23))
         || (bfu_pkg::addr_eq(v6_reg, rd_ent.a_words_01, rd_ent.a_words_23,
                              in_reg.dst_words_01, in_reg.dst_words_23)
          && bfu_pkg::addr_eq(v6_reg, rd_ent.b_words_01, rd_ent.b_words_23,
                              in_reg.src_words_01, in_reg.src_words_23)));

    // fresh flow built from the held header
    always_comb begin
        new_ent              = '0;
        new_ent.net_proto    = in_reg.net_proto;
        new_ent.trans_proto  = in_reg.trans_proto;
        new_ent.a_words_01   = in_reg.src_words_01;
        new_ent.a_words_23   = in_reg.src_words_23;
        new_ent.b_words_01   = in_reg.dst_words_01;
        new_ent.b_words_23   = in_reg.dst_words_23;
        new_ent.a_port       = in_reg.src_l4_port;
        new_ent.b_port       = in_reg.dst_l4_port;
        new_ent.number       = flow_num_reg;
    end

    // counter update of the selected flow
    assign len64 = 64'(in_reg.pkt_length);
    assign wsel  = hit_reg ? way_reg : free_way_reg;
    always_comb begin
        base_ent = hit_reg ? rd_ent : new_ent;
        up = !bfu_pkg::addr_eq(v6_reg, base_ent.a_words_01, base_ent.a_words_23,
                               in_reg.src_words_01, in_reg.src_words_23);
        if (up) begin
            base_ent.up_pkts   = base_ent.up_pkts + 64'd1;
            base_ent.up_octets = base_ent.up_octets + len64;
        end else begin
            base_ent.down_pkts   = base_ent.down_pkts + 64'd1;
            base_ent.down_octets = base_ent.down_octets + len64;
        end
        base_ent.total_pkts   = base_ent.total_pkts + 64'd1;
        base_ent.total_octets = base_ent.total_octets + len64;
        base_ent.seen_time    = in_reg.pkt_time;
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        bucket_count_next = cfg_we ? cfg_wdata : bucket_count_reg;
        clr_cnt_next      = clr_cnt_reg;
        flow_num_next     = flow_num_reg;
        hit_next          = hit_reg;
        free_found_next   = free_found_reg;
        free_way_next     = free_way_reg;
        way_next          = way_reg;
        in_next           = in_reg;
        v6_next           = v6_reg;
        bucket_next       = bucket_reg;
        out_next          = out_reg;
        hreq.start        = 1'b0;
        hreq.key          = key_fold;
        vr_we             = 1'b0;
        vr_re             = 1'b0;
        vr_waddr          = bucket_reg;
        vr_wdata          = '0;
        er_we             = 1'b0;
        er_re             = 1'b0;
        er_raddr          = bfu_pkg::ENTRY_W'(bucket_reg) * bfu_pkg::ENTRY_W'(bfu_pkg::WAYS)
                          + bfu_pkg::ENTRY_W'(way_reg);
        er_waddr          = bfu_pkg::ENTRY_W'(bucket_reg) * bfu_pkg::ENTRY_W'(bfu_pkg::WAYS)
                          + bfu_pkg::ENTRY_W'(wsel);
        s_ready           = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                // wipe one bucket's valid bits per cycle
                vr_we    = 1'b1;
                vr_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == bfu_pkg::BKT_W'(bfu_pkg::BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next         = s_data;
                    v6_next         = is_v6;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    way_next        = '0;
                    if (is_v4 || is_v6) begin
                        hreq.start = 1'b1;
                        state_next = S_HASH;
                    end else begin
                        out_next        = '0;
                        out_next.status = bfu_pkg::ST_PROTO;
                        state_next      = S_OUT;
                    end
                end
            end
            S_HASH: begin
                if (hrsp.done) begin
                    bucket_next = hrsp.bucket;
                    state_next  = S_RD;
                end
            end
            S_RD: begin
                vr_re      = 1'b1;
                er_re      = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (cur_valid && cur_match) begin
                    hit_next   = 1'b1;
                    state_next = S_UPD;
                end else begin
                    if (!cur_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_way_next   = way_reg;
                    end
                    if (way_reg == bfu_pkg::WAY_W'(bfu_pkg::WAYS - 1)) begin
                        state_next = S_UPD;
                    end else begin
                        way_next   = way_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_UPD: begin
                out_next   = '0;
                state_next = S_OUT;
                if (!hit_reg && !free_found_reg) begin
                    out_next.status = bfu_pkg::ST_FULL;
                end else begin
                    er_we = 1'b1;
                    if (!hit_reg) begin
                        vr_we         = 1'b1;
                        vr_wdata      = vr_rdata | (bfu_pkg::WAYS'(1) << free_way_reg);
                        flow_num_next = flow_num_reg + 32'd1;
                    end
                    out_next.status       = bfu_pkg::ST_OK;
                    out_next.flow_number  = base_ent.number;
                    out_next.is_new       = !hit_reg;
                    out_next.direction    = up;
                    out_next.up_pkts      = base_ent.up_pkts;
                    out_next.up_octets    = base_ent.up_octets;
                    out_next.down_pkts    = base_ent.down_pkts;
                    out_next.down_octets  = base_ent.down_octets;
                    out_next.total_pkts   = base_ent.total_pkts;
                    out_next.total_octets = base_ent.total_octets;
                    out_next.seen_time    = base_ent.seen_time;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            bucket_count_reg <= bfu_pkg::BC_RESET;
            clr_cnt_reg      <= '0;
            flow_num_reg     <= '0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            free_way_reg     <= '0;
            way_reg          <= '0;
        end else begin
            state_reg        <= state_next;
            bucket_count_reg <= bucket_count_next;
            clr_cnt_reg      <= clr_cnt_next;
            flow_num_reg     <= flow_num_next;
            hit_reg          <= hit_next;
            free_found_reg   <= free_found_next;
            free_way_reg     <= free_way_next;
            way_reg          <= way_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        v6_reg     <= v6_next;
        bucket_reg <= bucket_next;
        out_reg    <= out_next;
    end

    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted before the first finished");

    a_total_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == bfu_pkg::ST_OK)
            |-> (m_data.total_pkts == m_data.up_pkts + m_data.down_pkts))
        else $error("total packet count differs from the direction sum");

    a_new_flow_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == bfu_pkg::ST_OK && m_data.is_new)
            |-> (m_data.total_pkts == 64'd1))
        else $error("new flow does not start with one packet");

endmodule

### verif/tb_top.sv
// self-checking testbench for the bidirectional flow table update block
`timescale 1ns / 1ps

module tb_top;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int     HOLD_LEN    = 400;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [bfu_pkg::BC_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    bfu_pkg::in_t s_data;
    logic m_valid;
    logic m_ready;
    bfu_pkg::out_t m_data;

    bidirectional_flow_table_update DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic [bfu_pkg::ENTRIES-1:0] flow_used;
    bfu_pkg::entry_t flow_store [bfu_pkg::ENTRIES];
    logic [31:0] flow_id_next;
    logic [bfu_pkg::BC_W-1:0] bucket_reg;

    bfu_pkg::out_t result_fifo [$];
    int mismatch_count;
    longint cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int hold_token;
    int hold_seen;

    // recent flows for reuse in random traffic
    bfu_pkg::in_t flow_pool [$];

    // stimulus table for the directed part
    typedef struct {
        bfu_pkg::in_t hdr;
        logic known;
        bfu_pkg::out_t res;
    } dir_row_t;
    dir_row_t dir_rows [$];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // 32-bit integer mix
    function automatic logic [31:0] hash_key(input logic [31:0] k);
        logic [31:0] t;
        logic [63:0] prod;
        t = (k ^ 32'd61) ^ (k >> 16);
        t = t + (t << 3);
        t = t ^ (t >> 4);
        prod = t * 64'h27d4eb2d;
        t = prod[31:0];
        return t ^ (t >> 15);
    endfunction

    function automatic logic same_addr(input logic v6, input logic [63:0] x01,
                                       input logic [63:0] x23, input logic [63:0] y01,
                                       input logic [63:0] y23);
        if (!v6) return x01[31:0] == y01[31:0];
        return (x01 == y01) && (x23 == y23);
    endfunction

    // compute the expected result and update the flow store
    function automatic bfu_pkg::out_t update_flow(input bfu_pkg::in_t h);
        bfu_pkg::out_t r;
        logic v6;
        logic [31:0] key, p, nb, base;
        int hit, freew, e;
        bfu_pkg::entry_t en;
        logic up;
        r = '0;
        hit = -1;
        freew = -1;
        if (h.net_proto == bfu_pkg::PROTO_V4) begin
            v6 = 1'b0;
            key = h.src_words_01[31:0] ^ h.dst_words_01[31:0];
        end else if (h.net_proto == bfu_pkg::PROTO_V6) begin
            v6 = 1'b1;
            key = h.src_words_01[31:0] ^ h.dst_words_01[31:0] ^ h.src_words_01[63:32]
                ^ h.dst_words_01[63:32] ^ h.src_words_23[31:0] ^ h.dst_words_23[31:0]
                ^ h.src_words_23[63:32] ^ h.dst_words_23[63:32];
        end else begin
            r.status = bfu_pkg::ST_PROTO;
            return r;
        end
        p = {16'd0, h.src_l4_port ^ h.dst_l4_port};
        key ^= p | (p << 16);
        nb = 32'(bucket_reg);
        if (nb == 32'd0) nb = 32'd1;
        if (nb > 32'(bfu_pkg::BUCKETS)) nb = 32'(bfu_pkg::BUCKETS);
        base = (hash_key(key) % nb) * 32'(bfu_pkg::WAYS);
        for (int w = 0; w < bfu_pkg::WAYS; w++) begin
            en = flow_store[base + w];
            if (!flow_used[base + w]) begin
                if (freew < 0) freew = w;
                continue;
            end
            if (en.net_proto != h.net_proto || en.trans_proto != h.trans_proto) continue;
            if (!((en.a_port == h.src_l4_port && en.b_port == h.dst_l4_port) ||
                  (en.a_port == h.dst_l4_port && en.b_port == h.src_l4_port))) continue;
            if ((same_addr(v6, en.a_words_01, en.a_words_23, h.src_words_01, h.src_words_23)
                 && same_addr(v6, en.b_words_01, en.b_words_23, h.dst_words_01,
                              h.dst_words_23)) ||
                (same_addr(v6, en.a_words_01, en.a_words_23, h.dst_words_01, h.dst_words_23)
                 && same_addr(v6, en.b_words_01, en.b_words_23, h.src_words_01,
                              h.src_words_23))) begin
                hit = w;
                break;
            end
        end
        if (hit >= 0) begin
            e = base + hit;
            en = flow_store[e];
        end else begin
            if (freew < 0) begin
                r.status = bfu_pkg::ST_FULL;
                return r;
            end
            e = base + freew;
            en = '0;
            en.net_proto = h.net_proto;
            en.trans_proto = h.trans_proto;
            en.a_words_01 = h.src_words_01;
            en.a_words_23 = h.src_words_23;
            en.b_words_01 = h.dst_words_01;
            en.b_words_23 = h.dst_words_23;
            en.a_port = h.src_l4_port;
            en.b_port = h.dst_l4_port;
            en.number = flow_id_next;
            flow_id_next++;
            flow_used[e] = 1'b1;
            r.is_new = 1'b1;
        end
        en.seen_time = h.pkt_time;
        up = !same_addr(v6, en.a_words_01, en.a_words_23, h.src_words_01, h.src_words_23);
        if (up) begin
            en.up_pkts += 64'd1;
            en.up_octets += 64'(h.pkt_length);
        end else begin
            en.down_pkts += 64'd1;
            en.down_octets += 64'(h.pkt_length);
        end
        en.total_pkts += 64'd1;
        en.total_octets += 64'(h.pkt_length);
        flow_store[e] = en;
        r.status = bfu_pkg::ST_OK;
        r.flow_number = en.number;
        r.direction = up;
        r.up_pkts = en.up_pkts;
        r.up_octets = en.up_octets;
        r.down_pkts = en.down_pkts;
        r.down_octets = en.down_octets;
        r.total_pkts = en.total_pkts;
        r.total_octets = en.total_octets;
        r.seen_time = en.seen_time;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // result checker
    always @(posedge aclk) begin
        bfu_pkg::out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (result_fifo.size() == 0) begin
                report_mismatch("unexpected transaction", 64'd0, 64'd0);
            end else begin
                w = result_fifo.pop_front();
                if (m_data.status !== w.status)
                    report_mismatch("status", 64'(m_data.status), 64'(w.status));
                if (m_data.flow_number !== w.flow_number)
                    report_mismatch("flow_number", 64'(m_data.flow_number),
                                    64'(w.flow_number));
                if (m_data.is_new !== w.is_new)
                    report_mismatch("is_new", 64'(m_data.is_new), 64'(w.is_new));
                if (m_data.direction !== w.direction)
                    report_mismatch("direction", 64'(m_data.direction), 64'(w.direction));
                if (m_data.up_pkts !== w.up_pkts)
                    report_mismatch("up_pkts", m_data.up_pkts, w.up_pkts);
                if (m_data.up_octets !== w.up_octets)
                    report_mismatch("up_octets", m_data.up_octets, w.up_octets);
                if (m_data.down_pkts !== w.down_pkts)
                    report_mismatch("down_pkts", m_data.down_pkts, w.down_pkts);
                if (m_data.down_octets !== w.down_octets)
                    report_mismatch("down_octets", m_data.down_octets, w.down_octets);
                if (m_data.total_pkts !== w.total_pkts)
                    report_mismatch("total_pkts", m_data.total_pkts, w.total_pkts);
                if (m_data.total_octets !== w.total_octets)
                    report_mismatch("total_octets", m_data.total_octets, w.total_octets);
                if (m_data.seen_time !== w.seen_time)
                    report_mismatch("seen_time", m_data.seen_time, w.seen_time);
            end
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cycles <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_cycles <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(3))
            0: return 64'd0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // random header: mostly reused flows in either direction, some fresh, some noise
    function automatic bfu_pkg::in_t random_header();
        bfu_pkg::in_t h;
        int pick;
        logic [63:0] t01, t23;
        logic [15:0] tp;
        pick = $urandom_range(99);
        h.trans_proto = 8'($urandom);
        h.src_words_01 = edge64();
        h.src_words_23 = edge64();
        h.dst_words_01 = edge64();
        h.dst_words_23 = edge64();
        h.src_l4_port = 16'($urandom);
        h.dst_l4_port = 16'($urandom);
        h.pkt_length = 16'($urandom);
        h.pkt_time = rand64();
        h.net_proto = ($urandom_range(1)) ? bfu_pkg::PROTO_V4 : bfu_pkg::PROTO_V6;
        if (pick < 5) begin
            h.net_proto = 16'($urandom);
        end else if (pick < 60 && flow_pool.size() > 0) begin
            h = flow_pool[$urandom_range(flow_pool.size() - 1)];
            h.pkt_length = 16'($urandom);
            h.pkt_time = rand64();
            if ($urandom_range(1)) begin
                t01 = h.src_words_01; t23 = h.src_words_23; tp = h.src_l4_port;
                h.src_words_01 = h.dst_words_01; h.src_words_23 = h.dst_words_23;
                h.src_l4_port = h.dst_l4_port;
                h.dst_words_01 = t01; h.dst_words_23 = t23; h.dst_l4_port = tp;
            end
            // ipv4 ignores the upper words
            if (h.net_proto == bfu_pkg::PROTO_V4 && $urandom_range(3) == 0)
                h.src_words_01[63:32] = $urandom;
            if ($urandom_range(15) == 0) h.trans_proto = h.trans_proto + 8'd1;
        end else begin
            if (flow_pool.size() > 40) void'(flow_pool.pop_front());
            flow_pool.push_back(h);
        end
        return h;
    endfunction

    // offer one transaction; valid stays up from one item into the next unless idle cycles are drawn
    task automatic offer(input bfu_pkg::in_t h, input bfu_pkg::out_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= h;
        result_fifo.push_back(r);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_header(input bfu_pkg::in_t h);
        offer(h, update_flow(h));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (result_fifo.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_buckets(input logic [bfu_pkg::BC_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        bucket_reg = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bfu_pkg::in_t make_hdr(input logic [15:0] np, input logic [63:0] a,
                                              input logic [63:0] b, input logic [15:0] sp,
                                              input logic [15:0] dp, input logic [15:0] len);
        bfu_pkg::in_t h;
        h = '0;
        h.net_proto = np;
        h.trans_proto = 8'd6;
        h.src_words_01 = a;
        h.dst_words_01 = b;
        h.src_l4_port = sp;
        h.dst_l4_port = dp;
        h.pkt_length = len;
        h.pkt_time = {a[31:0], b[31:0]};
        return h;
    endfunction

    task automatic add_row(input bfu_pkg::in_t h, input logic known, input bfu_pkg::out_t r);
        dir_row_t row;
        row.hdr = h;
        row.known = known;
        row.res = r;
        dir_rows.push_back(row);
    endtask

    initial begin
        bfu_pkg::out_t r0;
        bfu_pkg::out_t pred;
        bfu_pkg::in_t h;
        int phase;
        mismatch_count = 0;
        flow_used = '0;
        flow_id_next = 0;
        bucket_reg = bfu_pkg::BC_RESET;
        send_idle_pct = 36;
        recv_idle_pct = 82;
        hold_token = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        r0 = '0;
        r0.status = bfu_pkg::ST_PROTO;
        add_row(make_hdr(16'h0000, 64'd1, 64'd2, 16'd1, 16'd2, 16'd9), 1, r0);
        add_row(make_hdr(16'hFFFF, '1, '1, '1, '1, '1), 1, r0);
        add_row(make_hdr(16'h0801, 64'd1, 64'd2, 16'd1, 16'd2, 16'd9), 1, r0);
        // first flow after reset
        r0 = '0;
        r0.status = bfu_pkg::ST_OK;
        r0.is_new = 1'b1;
        r0.down_pkts = 64'd1;
        r0.down_octets = 64'hFFFF;
        r0.total_pkts = 64'd1;
        r0.total_octets = 64'hFFFF;
        h = make_hdr(bfu_pkg::PROTO_V4, 64'h0A000001, 64'h0A000002, 16'd80, 16'd1234,
                     16'hFFFF);
        r0.seen_time = h.pkt_time;
        add_row(h, 1, r0);
        add_row(make_hdr(bfu_pkg::PROTO_V4, 64'h0A000002, 64'h0A000001, 16'd1234, 16'd80,
                         16'd0), 0, r0);
        add_row(make_hdr(bfu_pkg::PROTO_V4, 64'hFFFF_0A000001, 64'h0A000002, 16'd80,
                         16'd1234, 16'd5), 0, r0);
        add_row(make_hdr(bfu_pkg::PROTO_V6, '1, '1, '1, '1, '1), 0, r0);
        add_row(make_hdr(bfu_pkg::PROTO_V6, 64'd0, 64'd0, 16'd0, 16'd0, 16'd0), 0, r0);
        h = make_hdr(bfu_pkg::PROTO_V6, 64'h1, 64'h2, 16'd7, 16'd8, 16'd100);
        h.src_words_23 = '1;
        h.dst_words_23 = 64'h5555;
        add_row(h, 0, r0);
        h.src_words_23 = 64'h5555;
        h.dst_words_23 = '1;
        h.src_words_01 = 64'h2;
        h.dst_words_01 = 64'h1;
        add_row(h, 0, r0);
        add_row(make_hdr(bfu_pkg::PROTO_V4, '1, '1, '1, '1, '1), 0, r0);
        foreach (dir_rows[i]) begin
            pred = update_flow(dir_rows[i].hdr);
            offer(dir_rows[i].hdr, dir_rows[i].known ? dir_rows[i].res : pred);
        end
        drain();

        // bucket full: one bucket with many flows
        write_buckets(11'd1);
        for (int i = 0; i < 6; i++)
            send_header(make_hdr(bfu_pkg::PROTO_V4, 64'd100 + i, 64'd200, 16'd1, 16'd2,
                                 16'd3));
        drain();
        write_buckets(11'd0);
        for (int i = 0; i < 3; i++)
            send_header(make_hdr(bfu_pkg::PROTO_V4, 64'd300 + i, 64'd200, 16'd1, 16'd2,
                                 16'd3));
        drain();
        write_buckets(11'h7FF);

        // random phases over idling schemes and bucket settings
        for (phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 36; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: write_buckets(11'd1024);
                1: write_buckets(11'd3);
                2: write_buckets(11'd1025);
                3: write_buckets(11'd1023);
                4: write_buckets(11'd2);
                default: write_buckets(11'd512);
            endcase
            flow_pool.delete();
            if (phase == 2) hold_token++;
            for (int i = 0; i < 280; i++) send_header(random_header());
            drain();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### files.f
hdl/bfu_pkg.sv
hdl/bfu_ram.sv
hdl/bfu_hash.sv
hdl/bidirectional_flow_table_update.sv
verif/tb_top.sv
